// ===== hw/rtl/twma_pkg.sv =====
package twma_pkg;

  localparam int CAPACITY = 1024;
  localparam int CAP_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int TS_W     = 32;
  localparam int VAL_W    = 16;
  localparam int WIN_W    = 17;
  localparam int SUM_W    = VAL_W + CAP_W;
  localparam int ENTRY_W  = TS_W + VAL_W;

  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(3600);

  localparam int Q_DEPTH = 2;
  localparam int QP_W    = $clog2(Q_DEPTH);

  localparam int DIV_STEPS = SUM_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

  typedef struct packed {
    logic [TS_W-1:0]  stamp;
    logic [VAL_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } fe_out_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_LOAD   = 6'b000010,
    S_CHECK  = 6'b000100,
    S_APPEND = 6'b001000,
    S_DIV    = 6'b010000,
    S_DONE   = 6'b100000
  } back_state_t;

endpackage

// ===== hw/rtl/twma_front.sv =====
module twma_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  twma_pkg::item_t   in_item,
  input  logic              pop,
  output twma_pkg::fe_out_t fe_o
);
  import twma_pkg::*;

  item_t             q_r [Q_DEPTH];
  logic [QP_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QP_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QP_W:0]     fill_r, fill_nxt;
  logic              push, pop_ok;

  assign in_ready = (fill_r != (QP_W + 1)'(Q_DEPTH));
  assign push     = in_valid && in_ready;
  assign pop_ok   = pop && (fill_r != '0);

  assign fe_o.valid = (fill_r != '0);
  assign fe_o.item  = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push   ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop_ok ? rd_ptr_r + 1'b1 : rd_ptr_r;
    fill_nxt   = fill_r;
    if (push && !pop_ok) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop_ok && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

// ===== hw/rtl/twma_div.sv =====
module twma_div (
  input  logic               clk,
  input  logic               rst_n,
  input  twma_pkg::div_req_t req_i,
  output twma_pkg::div_rsp_t rsp_o
);
  import twma_pkg::*;

  logic [SUM_W-1:0]  quo_r, quo_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  dvs_r;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  logic [SUM_W-1:0]  dvd_r;
  logic [CNT_W:0]    trial;
  logic              qbit;

  assign trial = {rem_r, quo_r[SUM_W-1]};
  assign qbit  = (trial >= {1'b0, dvs_r});

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (req_i.start) begin
      quo_nxt = req_i.dividend;
      rem_nxt = '0;
      cnt_nxt = DCNT_W'(DIV_STEPS);
    end else if (cnt_r != '0) begin
      quo_nxt = {quo_r[SUM_W-2:0], qbit};
      rem_nxt = qbit ? CNT_W'(trial - {1'b0, dvs_r}) : trial[CNT_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DCNT_W'(1)) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (req_i.start) begin
      dvs_r <= req_i.divisor;
      dvd_r <= req_i.dividend;
    end
  end

  assign rsp_o.done     = done_r;
  assign rsp_o.quotient = quo_r;

  a_div_exact: assert property (@(posedge clk) disable iff (!rst_n)
    done_r && (dvs_r != '0) |->
      ({SUM_W'(0), quo_r} * {{(2*SUM_W-CNT_W){1'b0}}, dvs_r} <= {SUM_W'(0), dvd_r}) &&
      ({SUM_W'(0), quo_r} * {{(2*SUM_W-CNT_W){1'b0}}, dvs_r} + {{(2*SUM_W-CNT_W){1'b0}}, dvs_r}
        > {SUM_W'(0), dvd_r}))
    else $error("divider result out of range");

endmodule

// ===== hw/rtl/twma_back.sv =====
module twma_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [twma_pkg::WIN_W-1:0]    window_i,
  input  twma_pkg::fe_out_t             fe_i,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [twma_pkg::VAL_W-1:0]    out_window_mean,
  output logic [twma_pkg::CNT_W-1:0]    out_window_count
);
  import twma_pkg::*;

  back_state_t      state_r, state_nxt;
  logic [CAP_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0] mean_r, mean_nxt;
  logic [VAL_W-1:0] out_mean_r;
  logic [CNT_W-1:0] out_count_r;
  logic             load_out;
  logic             div_started_r;

  logic [ENTRY_W-1:0] mem [CAPACITY];
  item_t              rd_r;
  logic               wr_en;
  logic [CAP_W-1:0]   tail;
  logic [CAP_W:0]     tail_sum;
  logic [CAP_W-1:0]   head_inc;
  logic [TS_W-1:0]    age;
  logic               expired, full;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  assign age      = fe_i.item.stamp - rd_r.stamp;
  assign expired  = (age > {{(TS_W-WIN_W){1'b0}}, window_i});
  assign full     = (count_r == CNT_W'(CAPACITY));
  assign head_inc = (head_r == CAP_W'(CAPACITY - 1)) ? '0 : head_r + 1'b1;
  assign tail_sum = {1'b0, head_r} + (CAP_W + 1)'(count_r);
  assign tail     = (tail_sum >= (CAP_W + 1)'(CAPACITY)) ?
                    CAP_W'(tail_sum - (CAP_W + 1)'(CAPACITY)) : tail_sum[CAP_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    sum_nxt       = sum_r;
    mean_nxt      = mean_r;
    out_valid_nxt = out_valid_r && !out_ready;
    load_out      = 1'b0;
    wr_en         = 1'b0;
    pop           = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = sum_r;
    div_req.divisor  = count_r;
    case (state_r)
      S_IDLE: begin
        if (fe_i.valid) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (count_r == '0) begin
          state_nxt = S_APPEND;
        end else if (expired) begin
          sum_nxt   = sum_r - SUM_W'(rd_r.value);
          head_nxt  = head_inc;
          count_nxt = count_r - 1'b1;
          state_nxt = S_LOAD;
        end else begin
          if (full) begin
            sum_nxt   = sum_r - SUM_W'(rd_r.value);
            head_nxt  = head_inc;
            count_nxt = count_r - 1'b1;
          end
          state_nxt = S_APPEND;
        end
      end
      S_APPEND: begin
        wr_en     = 1'b1;
        pop       = 1'b1;
        count_nxt = count_r + 1'b1;
        sum_nxt   = sum_r + SUM_W'(fe_i.item.value);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        div_req.start = !div_rsp.done && !div_started_r;
        if (div_rsp.done) begin
          mean_nxt  = div_rsp.quotient[VAL_W-1:0];
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      head_r        <= '0;
      count_r       <= '0;
      sum_r         <= '0;
      out_valid_r   <= 1'b0;
      div_started_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      head_r        <= head_nxt;
      count_r       <= count_nxt;
      sum_r         <= sum_nxt;
      out_valid_r   <= out_valid_nxt;
      div_started_r <= (state_r == S_DIV) && !div_rsp.done;
    end
  end

  always_ff @(posedge clk) begin
    mean_r <= mean_nxt;
    if (load_out) begin
      out_mean_r  <= mean_r;
      out_count_r <= count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail] <= {fe_i.item.stamp, fe_i.item.value};
    end
  end

  always_ff @(posedge clk) begin
    rd_r <= item_t'(mem[head_r]);
  end

  twma_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  assign out_valid        = out_valid_r;
  assign out_window_mean  = out_mean_r;
  assign out_window_count = out_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_room_on_append: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_APPEND |-> !full && fe_i.valid)
    else $error("append without room or item");

  a_empty_sum: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == '0 |-> sum_r == '0)
    else $error("running sum nonzero with empty window");

  a_result_count: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid_r && out_window_count != '0)
    else $error("result issued with empty window");

endmodule

// ===== hw/rtl/time_window_moving_average.sv =====
// Time-window moving average of timestamped sensor samples.
// Input channel: in_valid/in_ready with in_timestamp_sec (seconds, wraps at
// 2^32) and in_sample_value. Each accepted beat yields exactly one result beat.
// Result channel: out_valid/out_ready with out_window_mean (truncated mean of
// the held samples) and out_window_count (samples held, at most 1024).
// Configuration: cfg_wr_en/cfg_wr_data set window_seconds, the maximum sample
// age kept; write only while the block is idle. Reset value is 3600.
// Per beat, the back end evicts the E expired samples one by one. Each eviction
// step takes a memory read state (LOAD) plus a compare state (CHECK) on the
// ring's single read port; the 26-step serial divider then holds the back end
// until its quotient is ready. The worst case walks the whole 1024-entry ring.
// A two-beat input queue keeps accepting while the back end works.
// Reset (synchronous, active low) empties the ring, the queue and the output
// register. When the receiver stalls, the finished result holds in the output
// register; the next result waits behind it, and input backs up once the
// queue fills.
module time_window_moving_average (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [twma_pkg::TS_W-1:0]    in_timestamp_sec,
  input  logic [twma_pkg::VAL_W-1:0]   in_sample_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [twma_pkg::VAL_W-1:0]   out_window_mean,
  output logic [twma_pkg::CNT_W-1:0]   out_window_count,
  input  logic                         cfg_wr_en,
  input  logic [twma_pkg::WIN_W-1:0]   cfg_wr_data
);
  import twma_pkg::*;

  logic [WIN_W-1:0] window_r;
  item_t            in_item;
  fe_out_t          fe;
  logic             pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WIN_RESET;
    end else if (cfg_wr_en) begin
      window_r <= cfg_wr_data;
    end
  end

  assign in_item.stamp = in_timestamp_sec;
  assign in_item.value = in_sample_value;

  twma_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .pop      (pop),
    .fe_o     (fe)
  );

  twma_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .window_i         (window_r),
    .fe_i             (fe),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_window_mean  (out_window_mean),
    .out_window_count (out_window_count)
  );

endmodule

// ===== tb/sv/time_window_moving_average_test.sv =====
module time_window_moving_average_test;
  timeunit 1ns;
  timeprecision 1ps;

  import twma_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int REPORT_LIMIT   = 50;

  typedef struct packed {
    logic [VAL_W-1:0] mean;
    logic [CNT_W-1:0] count;
  } average_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [TS_W-1:0]  in_timestamp_sec = '0;
  logic [VAL_W-1:0] in_sample_value = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [VAL_W-1:0] out_window_mean;
  logic [CNT_W-1:0] out_window_count;
  logic             cfg_wr_en = 1'b0;
  logic [WIN_W-1:0] cfg_wr_data = '0;

  // running-average model state
  logic [TS_W-1:0]  hist_stamp [CAPACITY];
  logic [VAL_W-1:0] hist_value [CAPACITY];
  logic [CAP_W-1:0] hist_head = '0;
  logic [CNT_W-1:0] hist_count = '0;
  logic [SUM_W-1:0] hist_sum = '0;
  logic [WIN_W-1:0] window_len = WIN_RESET;

  average_t pending_averages[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_cycles = 0;
  int quiet_cycles = 0;
  int mismatch_count = 0;
  int sample_count = 0;
  int average_count = 0;
  int window_writes = 0;
  int peak_occupancy = 0;
  int full_ring_drops = 0;

  time_window_moving_average dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_timestamp_sec (in_timestamp_sec),
    .in_sample_value  (in_sample_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_window_mean  (out_window_mean),
    .out_window_count (out_window_count),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  always #2 clk = ~clk;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("ERROR at %0t ns: %s", $time, what);
    end
  endtask

  task automatic drop_oldest_sample();
    hist_sum = hist_sum - SUM_W'(hist_value[hist_head]);
    hist_head = CAP_W'(hist_head + 1);
    hist_count = hist_count - 1'b1;
  endtask

  task automatic predict_average(input logic [TS_W-1:0] stamp, input logic [VAL_W-1:0] value);
    logic [TS_W-1:0]  age;
    logic [CAP_W-1:0] tail;
    average_t         avg;
    while (hist_count != 0) begin
      age = stamp - hist_stamp[hist_head];
      if (age <= TS_W'(window_len)) break;
      drop_oldest_sample();
    end
    if (hist_count >= CNT_W'(CAPACITY)) begin
      drop_oldest_sample();
      full_ring_drops++;
    end
    tail = CAP_W'(hist_head + hist_count);
    hist_stamp[tail] = stamp;
    hist_value[tail] = value;
    hist_count = hist_count + 1'b1;
    hist_sum = hist_sum + SUM_W'(value);
    if (int'(hist_count) > peak_occupancy) peak_occupancy = int'(hist_count);
    avg.count = hist_count;
    avg.mean = (hist_count != 0) ? VAL_W'(hist_sum / hist_count) : '0;
    pending_averages.push_back(avg);
  endtask

  task automatic send_sample(input logic [TS_W-1:0] stamp, input logic [VAL_W-1:0] value);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_timestamp_sec <= stamp;
    in_sample_value <= value;
    do @(posedge clk); while (!in_ready);
    sample_count++;
    predict_average(stamp, value);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_averages.size() != 0) @(negedge clk);
  endtask

  task automatic set_window(input logic [WIN_W-1:0] seconds);
    wait_drained();
    repeat (8) @(negedge clk);
    cfg_wr_data <= seconds;
    cfg_wr_en <= 1'b1;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    window_len = seconds;
    window_writes++;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  task automatic test_directed();
    send_sample(32'd0, 16'h0000);
    send_sample(32'd3600, 16'hFFFF);
    send_sample(32'd3601, 16'hFFFF);
    send_sample(32'd3601, 16'h5555);
    send_sample(32'hFFFF_FFFF, 16'hAAAA);
    send_sample(32'd0, 16'h0001);
    send_sample(32'd5000, 16'h8000);
    send_sample(32'd4000, 16'h7FFF);
    // zero window: keep equal stamps only
    set_window('0);
    send_sample(32'd10, 16'h1234);
    send_sample(32'd10, 16'hFEDC);
    send_sample(32'd10, 16'h0F0F);
    send_sample(32'd11, 16'h4321);
    set_window(WIN_W'(1));
    send_sample(32'd20, 16'h0002);
    send_sample(32'd21, 16'h0004);
    send_sample(32'd22, 16'h0008);
    set_window('1);
    send_sample(32'd0, 16'hFFFF);
    send_sample(32'd131071, 16'h0000);
    send_sample(32'd131072, 16'hFFFF);
    set_window(WIN_W'(86400));
    send_sample(32'd1000, 16'hFFFF);
    send_sample(32'd87400, 16'h0000);
    send_sample(32'd87401, 16'h0001);
  endtask

  task automatic test_fill_ring();
    logic [TS_W-1:0]  base;
    logic [VAL_W-1:0] value;
    int               i;
    set_window(WIN_W'(86400));
    base = $urandom;
    for (i = 0; i < 1030; i++) begin
      value = ($urandom_range(0, 3) == 0) ? VAL_W'($urandom) : {VAL_W{1'b1}};
      send_sample(base + TS_W'(i / 32), value);
    end
    // expire the whole ring in one beat
    send_sample(base + 32'd200000, VAL_W'($urandom));
    wait_drained();
  endtask

  task automatic test_random_mix(input int per_window);
    logic [WIN_W-1:0] seconds;
    logic [TS_W-1:0]  stamp;
    logic [VAL_W-1:0] value;
    int unsigned      stride;
    int               k;
    int               i;
    int               pick;
    for (k = 0; k < 6; k++) begin
      case (k)
        0: seconds = WIN_W'(1);
        1: seconds = WIN_W'($urandom_range(2, 300));
        2: seconds = WIN_W'(86400);
        3: seconds = '1;
        4: seconds = '0;
        default: seconds = WIN_W'($urandom_range(301, 86399));
      endcase
      set_window(seconds);
      stamp = $urandom;
      stride = seconds / 6 + 1;
      for (i = 0; i < per_window; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          stamp = $urandom;
        end else if (pick < 14) begin
          stamp = stamp + TS_W'(seconds);
        end else begin
          stamp = stamp + TS_W'($urandom_range(0, stride));
        end
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          value = '0;
        end else if (pick == 1) begin
          value = '1;
        end else begin
          value = VAL_W'($urandom);
        end
        send_sample(stamp, value);
      end
    end
  endtask

  task automatic test_backpressure();
    logic [TS_W-1:0] stamp;
    int              i;
    stamp = $urandom;
    stall_cycles = 500;
    for (i = 0; i < 16; i++) begin
      send_sample(stamp + TS_W'(i), VAL_W'($urandom));
    end
    // pause until every average is back
    wait_drained();
    for (i = 16; i < 24; i++) begin
      send_sample(stamp + TS_W'(i), VAL_W'($urandom));
    end
    wait_drained();
  endtask

  always @(negedge clk) begin
    if (stall_cycles != 0) begin
      out_ready <= 1'b0;
      stall_cycles = stall_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    average_t avg;
    if (rst_n && out_valid && out_ready) begin
      if (pending_averages.size() == 0) begin
        report_mismatch($sformatf("result beat mean %0d count %0d with nothing pending",
                                  out_window_mean, out_window_count));
      end else begin
        avg = pending_averages.pop_front();
        average_count++;
        if (out_window_mean !== avg.mean) begin
          report_mismatch($sformatf("beat %0d: mean %0d, expected %0d", average_count,
                                    out_window_mean, avg.mean));
        end
        if (out_window_count !== avg.count) begin
          report_mismatch($sformatf("beat %0d: count %0d, expected %0d", average_count,
                                    out_window_count, avg.count));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("ERROR: no beat moved for %0d cycles, %0d averages outstanding",
               quiet_cycles, pending_averages.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_idling(35, 67);
    test_directed();
    test_fill_ring();
    set_idling(67, 35);
    test_random_mix(8);
    set_idling(0, 0);
    test_backpressure();
    test_random_mix(6);

    wait_drained();
    repeat (64) @(posedge clk);
    if (pending_averages.size() != 0) begin
      report_mismatch($sformatf("%0d averages never arrived", pending_averages.size()));
    end
    $display("Sent %0d samples and checked %0d averages over %0d window settings.",
             sample_count, average_count, window_writes);
    $display("Ring peaked at %0d of %0d entries with %0d overflow drops.",
             peak_occupancy, CAPACITY, full_ring_drops);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/twma_pkg.sv
hw/rtl/twma_front.sv
hw/rtl/twma_div.sv
hw/rtl/twma_back.sv
hw/rtl/time_window_moving_average.sv
tb/sv/time_window_moving_average_test.sv
